>>> src/e2q_pkg.sv
// Package: shared constants and functions for the Euler-to-quaternion unit
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

    localparam int Q15_W = 16;
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sd32767;

    typedef logic signed [Q15_W-1:0] q15_t;

    typedef struct packed {
        q15_t w;
        q15_t x;
        q15_t y;
        q15_t z;
    } quat_t;

    function automatic logic signed [CORDIC_W-1:0] atan_entry(input int idx);
        logic signed [CORDIC_W-1:0] t;
        case (idx)
            0: t = 34'sd536870912;
            1: t = 34'sd316933406;
            2: t = 34'sd167458907;
            3: t = 34'sd85004756;
            4: t = 34'sd42667331;
            5: t = 34'sd21354465;
            6: t = 34'sd10679838;
            7: t = 34'sd5340245;
            8: t = 34'sd2670163;
            9: t = 34'sd1335087;
            10: t = 34'sd667544;
            11: t = 34'sd333772;
            12: t = 34'sd166886;
            13: t = 34'sd83443;
            14: t = 34'sd41722;
            15: t = 34'sd20861;
            16: t = 34'sd10430;
            17: t = 34'sd5215;
            18: t = 34'sd2608;
            19: t = 34'sd1304;
            20: t = 34'sd652;
            21: t = 34'sd326;
            22: t = 34'sd163;
            23: t = 34'sd81;
            24: t = 34'sd41;
            25: t = 34'sd20;
            26: t = 34'sd10;
            27: t = 34'sd5;
            28: t = 34'sd3;
            29: t = 34'sd1;
            30: t = 34'sd1;
            default: t = 34'sd0;
        endcase
        return t;
    endfunction

    // Round a Q2.30 sum to Q1.15 and clamp to +-32767
    function automatic q15_t round_sat(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v + 36'sd16384) >>> 15;
        if (r > 36'sd32767)
            return Q15_MAX;
        else if (r < -36'sd32767)
            return -Q15_MAX;
        else
            return r[Q15_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: one register stage per iteration
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire logic                clk,
    input  wire logic                advance,
    input  wire logic signed [31:0]  half_angle,
    output e2q_pkg::q15_t            cos_out,
    output e2q_pkg::q15_t            sin_out
);
    localparam int W = e2q_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [1:ITERATIONS];
    logic signed [W-1:0] y_reg [1:ITERATIONS];
    logic signed [W-1:0] z_reg [1:ITERATIONS];

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        logic signed [W-1:0] x_cur, y_cur, z_cur;
        logic signed [W-1:0] x_next, y_next, z_next;
        // First stage starts from the gain-compensated unit vector
        if (i == 0) begin : g_first
            assign x_cur = e2q_pkg::CORDIC_GAIN;
            assign y_cur = '0;
            assign z_cur = W'(half_angle);
        end else begin : g_rest
            assign x_cur = x_reg[i];
            assign y_cur = y_reg[i];
            assign z_cur = z_reg[i];
        end
        always_comb
        begin
            if (!z_cur[W-1]) begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - e2q_pkg::atan_entry(i);
            end else begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + e2q_pkg::atan_entry(i);
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance) begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
            end
        end
    end

    assign cos_out = e2q_pkg::round_sat(36'(x_reg[ITERATIONS]));
    assign sin_out = e2q_pkg::round_sat(36'(y_reg[ITERATIONS]));
endmodule
`default_nettype wire

>>> src/e2q_hamilton.sv
// Two-stage Hamilton product: registered products, then registered sums
`timescale 1ns / 1ps
`default_nettype none
module e2q_hamilton (
    input  wire logic      clk,
    input  wire logic      advance,
    input  e2q_pkg::quat_t a,
    input  e2q_pkg::quat_t b,
    output e2q_pkg::quat_t r
);
    logic signed [31:0] p_reg [16];
    e2q_pkg::quat_t r_reg;
    logic signed [15:0] av [4];
    logic signed [15:0] bv [4];

    always_comb
    begin
        av[0] = a.w; av[1] = a.x; av[2] = a.y; av[3] = a.z;
        bv[0] = b.w; bv[1] = b.x; bv[2] = b.y; bv[3] = b.z;
    end

    // Hold all sixteen partial products
    always_ff @(posedge clk)
    begin
        if (advance) begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    p_reg[i*4+j] <= av[i] * bv[j];
        end
    end

    function automatic logic signed [35:0] ext(input logic signed [31:0] v);
        return 36'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (advance) begin
            r_reg.w <= e2q_pkg::round_sat(ext(p_reg[0]) - ext(p_reg[5])
                       - ext(p_reg[10]) - ext(p_reg[15]));
            r_reg.x <= e2q_pkg::round_sat(ext(p_reg[1]) + ext(p_reg[4])
                       + ext(p_reg[11]) - ext(p_reg[14]));
            r_reg.y <= e2q_pkg::round_sat(ext(p_reg[2]) - ext(p_reg[7])
                       + ext(p_reg[8]) + ext(p_reg[13]));
            r_reg.z <= e2q_pkg::round_sat(ext(p_reg[3]) + ext(p_reg[6])
                       - ext(p_reg[9]) + ext(p_reg[12]));
        end
    end

    assign r = r_reg;
endmodule
`default_nettype wire

>>> src/euler_to_quaternion_unit.sv
// Top level: Euler angles (z-y-x) to orientation quaternion, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// Takes roll, pitch and yaw as binary angles (2^(ANGLE_BITS-1) is pi) and
// returns q = qz*(qy*qx) in Q1.15, each component rounded and clamped to
// +-32767. One request is taken every cycle while the output is not stalled.
// Each request passes the CORDIC iteration registers (three CORDICs run side
// by side), the rounded sine/cosine registers, then both Hamilton products.
// The whole pipeline advances together; when the output is stalled a full
// pipeline freezes, and an empty output slot never holds the line back, so
// no request is lost or repeated.
module euler_to_quaternion_unit #(
    parameter int ANGLE_BITS        = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: roll_angle, pitch_angle, yaw_angle (lowest bits first)
    input  wire logic [3*ANGLE_BITS-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // tdata: quat_w, quat_x, quat_y, quat_z (lowest bits first)
    output logic [63:0]                  m_axis_tdata
);
    localparam int DEPTH = CORDIC_ITERATIONS + 5;

    logic [DEPTH-1:0] valid_reg;
    logic             advance;

    // Advance while the last slot is empty or being taken; the whole line moves
    assign advance       = !valid_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // Scale to a 32-bit binary angle, then halve by a floor shift
    function automatic logic signed [31:0] halve(input logic [ANGLE_BITS-1:0] a);
        logic signed [32:0] s;
        s = 33'(signed'(a)) <<< (32 - ANGLE_BITS);
        return s[32:1];
    endfunction

    e2q_pkg::q15_t c_x, s_x, c_y, s_y, c_z, s_z;

    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_roll (
        .clk(clk), .advance(advance),
        .half_angle(halve(s_axis_tdata[ANGLE_BITS-1:0])),
        .cos_out(c_x), .sin_out(s_x));
    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_pitch (
        .clk(clk), .advance(advance),
        .half_angle(halve(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS])),
        .cos_out(c_y), .sin_out(s_y));
    e2q_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_yaw (
        .clk(clk), .advance(advance),
        .half_angle(halve(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS])),
        .cos_out(c_z), .sin_out(s_z));

    // Register the rounded factors; qz is delayed to meet the inner product
    e2q_pkg::quat_t qx_reg, qy_reg, qz_reg, qz_d1_reg, qz_d2_reg;
    e2q_pkg::quat_t p_q, r_q;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            qx_reg    <= '{w: c_x, x: s_x, y: '0, z: '0};
            qy_reg    <= '{w: c_y, x: '0, y: s_y, z: '0};
            qz_reg    <= '{w: c_z, x: '0, y: '0, z: s_z};
            qz_d1_reg <= qz_reg;
            qz_d2_reg <= qz_d1_reg;
        end
    end

    e2q_hamilton u_inner (.clk(clk), .advance(advance), .a(qy_reg), .b(qx_reg), .r(p_q));
    e2q_hamilton u_outer (.clk(clk), .advance(advance), .a(qz_d2_reg), .b(p_q), .r(r_q));

    assign m_axis_tdata = {r_q.z, r_q.y, r_q.x, r_q.w};

    // Stalled output holds its request
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");
    // Saturation never yields -32768
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> r_q.w != 16'h8000 && r_q.x != 16'h8000
                          && r_q.y != 16'h8000 && r_q.z != 16'h8000)
        else $error("component reached -32768");
    // Accepted request enters the first pipeline slot
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted request lost");
endmodule
`default_nettype wire

>>> verif/euler_to_quaternion_unit_tb.sv
// Testbench: Euler angles to quaternion unit, streaming stimulus against an independent predictor
`timescale 1ns / 1ps
module euler_to_quaternion_unit_tb;

    localparam int LATENCY = 16 + 5;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // roll, pitch, yaw from the lowest bits up
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // w, x, y, z from the lowest bits up

    euler_to_quaternion_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Angle requests waiting to be driven, quaternions still owed by the block
    logic [47:0] angle_queue[$];
    logic [63:0] quat_expected[$];

    int     mismatch_count;
    longint cycle_count;
    int     burst_left;
    int     gap_left;
    bit     hold_sender;     // sender parks until the block has drained
    int     long_stall;      // requested long receiver hold-off
    int     stall_left;
    logic [47:0] current_req;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Arithmetic shift that rounds towards minus infinity
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint to_q15(input longint v);
        longint r;
        r = floor_shift(v + 16384, 15);
        if (r > 32767)
            r = 32767;
        if (r < -32767)
            r = -32767;
        return r;
    endfunction

    // Half angle in 32-bit binary-angle units, then rotation-mode CORDIC
    function automatic void sin_cos(input logic [15:0] raw, output longint c,
                                    output longint s);
        longint ang;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint step_angle[16];
        step_angle = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861};
        ang = longint'($signed(raw)) * 65536;
        ang = floor_shift(ang, 1);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (ang >= 0)
            begin
                x -= dx;
                y += dy;
                ang -= step_angle[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                ang += step_angle[i];
            end
        end
        c = to_q15(x);
        s = to_q15(y);
    endfunction

    function automatic void hamilton_product(input longint a[4], input longint b[4],
                                             output longint r[4]);
        r[0] = to_q15(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
        r[1] = to_q15(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
        r[2] = to_q15(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
        r[3] = to_q15(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
    endfunction

    function automatic logic [63:0] predict_quaternion(input logic [47:0] angles);
        longint qx[4];
        longint qy[4];
        longint qz[4];
        longint inner[4];
        longint outer[4];
        qx = '{0, 0, 0, 0};
        qy = '{0, 0, 0, 0};
        qz = '{0, 0, 0, 0};
        sin_cos(angles[15:0], qx[0], qx[1]);
        sin_cos(angles[31:16], qy[0], qy[2]);
        sin_cos(angles[47:32], qz[0], qz[3]);
        hamilton_product(qy, qx, inner);
        hamilton_product(qz, inner, outer);
        return {outer[3][15:0], outer[2][15:0], outer[1][15:0], outer[0][15:0]};
    endfunction

    function automatic logic [15:0] random_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(16'sd16384 * $signed(2'($urandom_range(0, 3))));
            4: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // Driver: bursts and gaps, inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                // the previous request (if any) was taken at the last rising edge
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (angle_queue.size() > 0 && !hold_sender && burst_left > 0)
                begin
                    current_req = angle_queue.pop_front();
                    s_axis_tdata <= current_req;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off on request
    always @(negedge clk)
    begin
        if (long_stall > 0)
        begin
            stall_left = long_stall;
            long_stall = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ((cycle_count / 64) % 3 == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: log accepted requests, check accepted results in order
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            quat_expected.push_back(predict_quaternion(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (quat_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected quaternion %h", m_axis_tdata);
            end
            else
            begin
                if (quat_expected[0] !== m_axis_tdata)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("quaternion w/x/y/z expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $signed(quat_expected[0][15:0]), $signed(quat_expected[0][31:16]),
                                 $signed(quat_expected[0][47:32]), $signed(quat_expected[0][63:48]),
                                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                                 $signed(m_axis_tdata[47:32]), $signed(m_axis_tdata[63:48]));
                end
                void'(quat_expected.pop_front());
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (angle_queue.size() > 0 || s_axis_tvalid || quat_expected.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] extremes[6];
        extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'hffff};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        hold_sender = 1'b0;
        long_stall = 0;
        stall_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each axis alone at the extremes, then all three together
        for (int k = 0; k < 6; k++)
        begin
            angle_queue.push_back({16'h0000, 16'h0000, extremes[k]});
            angle_queue.push_back({16'h0000, extremes[k], 16'h0000});
            angle_queue.push_back({extremes[k], 16'h0000, 16'h0000});
        end
        angle_queue.push_back({16'h8000, 16'h8000, 16'h8000});
        angle_queue.push_back({16'h7fff, 16'h7fff, 16'h7fff});
        angle_queue.push_back({16'h4000, 16'hc000, 16'h4000});
        angle_queue.push_back({16'hffff, 16'hffff, 16'hffff});
        wait_drained();

        // Random, with a long output hold-off so the pipeline fills and backs up
        for (int n = 0; n < 1100; n++)
        begin
            angle_queue.push_back({random_angle(), random_angle(), random_angle()});
            if (n == 300)
            begin
                long_stall = 200;
                while (angle_queue.size() > 0)
                    @(posedge clk);
            end
            if (n == 700)
            begin
                // park the sender until every owed result is back
                while (angle_queue.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (quat_expected.size() > 0 || s_axis_tvalid)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
        end
        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> euler_to_quaternion_unit.f
src/e2q_pkg.sv
src/e2q_cordic.sv
src/e2q_hamilton.sv
src/euler_to_quaternion_unit.sv
verif/euler_to_quaternion_unit_tb.sv
